FILE: rtl/core/mfde_pkg.sv
package mfde_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;

    // Widest byte address that any legal screen size needs (255 x 31 pages).
    localparam int MAX_ADDR_W = 13;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 8;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [PADDR_W-1:0] ADDR_INVERT_COLOUR = 3'd0;

    typedef enum logic [2:0] {
        OP_PIXEL  = 3'd0,
        OP_FILL   = 3'd1,
        OP_RECT   = 3'd2,
        OP_CIRCLE = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef struct packed {
        logic [9:0] byte_address;
        logic       colour;
        logic [6:0] circle_radius;
        logic [7:0] y_second;
        logic [7:0] x_second;
        logic [7:0] y_first;
        logic [7:0] x_first;
        logic [2:0] op;
    } cmd_t;

    typedef struct packed {
        logic                  valid;
        logic [MAX_ADDR_W-1:0] addr;
        logic [7:0]            mask;
        logic                  set;
    } wr_req_t;

    typedef enum logic [1:0] {
        WK_IDLE,
        WK_PT,
        WK_STEP,
        WK_RECT
    } wk_state_t;

    typedef enum logic [2:0] {
        T_SWEEP,
        T_IDLE,
        T_DRAW,
        T_DRAW_WR,
        T_READ,
        T_READ_WAIT
    } top_state_t;

endpackage

FILE: rtl/core/mfde_ram.sv
module mfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/mfde_walker.sv
// Turns one drawing command into a series of masked byte updates. Pixels and
// circle points give one bit each; rectangles give one byte per column and page.
module mfde_walker #(
    parameter int SCREEN_WIDTH  = mfde_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mfde_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mfde_pkg::cmd_t    cmd,
    input  logic              invert,
    input  logic              take,
    output mfde_pkg::wr_req_t acc,
    output logic              busy
);
    import mfde_pkg::*;

    localparam int PAGES   = (SCREEN_HEIGHT + 7) / 8;
    localparam int ADDR_W  = $clog2(SCREEN_WIDTH * PAGES);

    wk_state_t         state_reg, state_next;
    logic              single_reg, single_next;
    logic              set_reg, set_next;
    logic [2:0]        pt_reg, pt_next;
    logic [7:0]        cx_reg, cx_next;
    logic [7:0]        cy_reg, cy_next;
    logic [6:0]        x_reg, x_next;
    logic [6:0]        y_reg, y_next;
    logic signed [11:0] f_reg, f_next;
    logic signed [11:0] ddx_reg, ddx_next;
    logic signed [11:0] ddy_reg, ddy_next;
    logic [7:0]        col_reg, col_next;
    logic [7:0]        col_lo_reg, col_lo_next;
    logic [7:0]        col_end_reg, col_end_next;
    logic [4:0]        page_reg, page_next;
    logic [4:0]        page_end_reg, page_end_next;
    logic [7:0]        ylo_reg, ylo_next;
    logic [7:0]        yend_reg, yend_next;

    // Point selection for the eight-way symmetry.
    logic [6:0] da, db;
    logic [9:0] px, py;
    logic       pt_ok;
    logic       advance;
    logic       rect_last_col, rect_last;

    // Rectangle setup.
    logic [7:0] lo_x, hi_x, lo_y, hi_y, xend, yend;
    logic       rect_empty;

    // Circle step.
    logic              f_pos;
    logic [6:0]        y_s;
    logic signed [11:0] ddy_s, f_s, ddx_s;

    // Address and mask.
    logic [4:0]        sel_page;
    logic [7:0]        sel_col;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
    logic [7:0]        row;

    always_comb
    begin
        da = (pt_reg[2]) ? y_reg : x_reg;
        db = (pt_reg[2]) ? x_reg : y_reg;
        px = (pt_reg[0]) ? ({2'b00, cx_reg} - {3'b000, da}) : ({2'b00, cx_reg} + {3'b000, da});
        py = (pt_reg[1]) ? ({2'b00, cy_reg} - {3'b000, db}) : ({2'b00, cy_reg} + {3'b000, db});
        pt_ok = !px[9] && (px < 10'(SCREEN_WIDTH)) && !py[9] && (py < 10'(SCREEN_HEIGHT));

        lo_x = (cmd.x_first < cmd.x_second) ? cmd.x_first : cmd.x_second;
        hi_x = (cmd.x_first < cmd.x_second) ? cmd.x_second : cmd.x_first;
        lo_y = (cmd.y_first < cmd.y_second) ? cmd.y_first : cmd.y_second;
        hi_y = (cmd.y_first < cmd.y_second) ? cmd.y_second : cmd.y_first;
        xend = (hi_x > 8'(SCREEN_WIDTH - 1)) ? 8'(SCREEN_WIDTH - 1) : hi_x;
        yend = (hi_y > 8'(SCREEN_HEIGHT)) ? 8'(SCREEN_HEIGHT) : hi_y;
        rect_empty = (lo_x > xend) || (lo_y >= yend);

        f_pos = !f_reg[11];
        y_s   = f_pos ? (y_reg - 7'd1) : y_reg;
        ddy_s = f_pos ? (ddy_reg + 12'sd2) : ddy_reg;
        f_s   = f_pos ? (f_reg + ddy_s) : f_reg;
        ddx_s = ddx_reg + 12'sd2;

        rect_last_col = (col_reg == col_end_reg);
        rect_last     = rect_last_col && (page_reg == page_end_reg);
    end

    // Address and mask of the byte being presented.
    always_comb
    begin
        if (state_reg == WK_RECT)
        begin
            sel_page = page_reg;
            sel_col  = col_reg;
            for (int b = 0; b < 8; b++)
            begin
                row     = {page_reg, 3'(b)};
                mask[b] = (row >= ylo_reg) && (row < yend_reg);
            end
        end
        else
        begin
            sel_page = py[7:3];
            sel_col  = px[7:0];
            row      = 8'd0;
            mask     = 8'(1) << py[2:0];
        end
        addr = ADDR_W'(sel_page) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(sel_col);
    end

    always_comb
    begin
        acc.valid = ((state_reg == WK_PT) && pt_ok) || (state_reg == WK_RECT);
        acc.addr  = MAX_ADDR_W'(addr);
        acc.mask  = mask;
        acc.set   = set_reg;
        busy      = (state_reg != WK_IDLE);
        advance   = !acc.valid || take;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            WK_IDLE:
            begin
                if (start)
                begin
                    case (op_t'(cmd.op))
                        OP_PIXEL:  state_next = WK_PT;
                        OP_CIRCLE: state_next = WK_PT;
                        OP_RECT:   state_next = rect_empty ? WK_IDLE : WK_RECT;
                        default:   state_next = WK_IDLE;
                    endcase
                end
            end
            WK_PT:
            begin
                if (advance && (single_reg || pt_reg == 3'd7))
                begin
                    state_next = single_reg ? WK_IDLE : WK_STEP;
                end
            end
            WK_STEP:
            begin
                state_next = (x_reg < y_reg) ? WK_PT : WK_IDLE;
            end
            WK_RECT:
            begin
                if (take && rect_last)
                begin
                    state_next = WK_IDLE;
                end
            end
            default: state_next = WK_IDLE;
        endcase
    end

    // Datapath.
    always_comb
    begin
        single_next   = single_reg;
        set_next      = set_reg;
        pt_next       = pt_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        f_next        = f_reg;
        ddx_next      = ddx_reg;
        ddy_next      = ddy_reg;
        col_next      = col_reg;
        col_lo_next   = col_lo_reg;
        col_end_next  = col_end_reg;
        page_next     = page_reg;
        page_end_next = page_end_reg;
        ylo_next      = ylo_reg;
        yend_next     = yend_reg;
        case (state_reg)
            WK_IDLE:
            begin
                if (start)
                begin
                    set_next      = cmd.colour ^ invert;
                    pt_next       = 3'd0;
                    cx_next       = cmd.x_first;
                    cy_next       = cmd.y_first;
                    single_next   = (op_t'(cmd.op) == OP_PIXEL);
                    x_next        = 7'd0;
                    y_next        = (op_t'(cmd.op) == OP_PIXEL) ? 7'd0 : cmd.circle_radius;
                    f_next        = 12'sd1 - $signed({5'b0, cmd.circle_radius});
                    ddx_next      = 12'sd1;
                    ddy_next      = -$signed({4'b0, cmd.circle_radius, 1'b0});
                    col_next      = lo_x;
                    col_lo_next   = lo_x;
                    col_end_next  = xend;
                    page_next     = lo_y[7:3];
                    page_end_next = 5'((yend - 8'd1) >> 3);
                    ylo_next      = lo_y;
                    yend_next     = yend;
                end
            end
            WK_PT:
            begin
                if (advance)
                begin
                    pt_next = pt_reg + 3'd1;
                end
            end
            WK_STEP:
            begin
                if (x_reg < y_reg)
                begin
                    y_next   = y_s;
                    ddy_next = ddy_s;
                    x_next   = x_reg + 7'd1;
                    ddx_next = ddx_s;
                    f_next   = f_s + ddx_s;
                    pt_next  = 3'd0;
                end
            end
            WK_RECT:
            begin
                if (take)
                begin
                    if (rect_last_col)
                    begin
                        col_next  = col_lo_reg;
                        page_next = page_reg + 5'd1;
                    end
                    else
                    begin
                        col_next = col_reg + 8'd1;
                    end
                end
            end
            default:
            begin
                pt_next = pt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= WK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        single_reg   <= single_next;
        set_reg      <= set_next;
        pt_reg       <= pt_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        f_reg        <= f_next;
        ddx_reg      <= ddx_next;
        ddy_reg      <= ddy_next;
        col_reg      <= col_next;
        col_lo_reg   <= col_lo_next;
        col_end_reg  <= col_end_next;
        page_reg     <= page_next;
        page_end_reg <= page_end_next;
        ylo_reg      <= ylo_next;
        yend_reg     <= yend_next;
    end

endmodule

FILE: rtl/core/mono_framebuffer_draw_engine.sv
// Monochrome page framebuffer with a small drawing engine. The buffer holds one
// byte per column per 8-row page (bit y mod 8 of byte (y / 8) * SCREEN_WIDTH + x
// is pixel (x, y)) and lives in a single synchronous RAM. Each request on the
// input stream is one command: set or clear a pixel, fill the whole buffer, fill
// a rectangle, draw a midpoint circle outline, or read one byte back. Only the
// read command produces an output request. Every drawn pixel is clipped to the
// screen and its colour is inverted when the invert_colour register is set; the
// fill command ignores that register. Timing is set by the RAM's single read and
// write port, since every update is a read followed by a write. A command is
// taken only in the idle state. A pixel is a read and a write-back, with no
// write when it is clipped; a rectangle reads and writes back each byte touched
// (one column of one page); a circle reads and writes back each visible point,
// with 8 points for the axis pass and 8 per loop iteration, plus a step per
// iteration. A fill writes all SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8) bytes, and
// after reset the same sweep clears the buffer with no command accepted; register
// writes are taken at any time. A read of an address beyond the buffer gives zero
// without a RAM read, and every read waits for the output register to be free.
module mono_framebuffer_draw_engine #(
    parameter int SCREEN_WIDTH  = mfde_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mfde_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Command stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // From bit 0: op[2:0], x_first[10:3], y_first[18:11], x_second[26:19],
    // y_second[34:27], circle_radius[41:35], colour[42], byte_address[52:43],
    // zero padding[55:53].
    input  logic [mfde_pkg::IN_DATA_W-1:0]  s_tdata,
    // Read result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // From bit 0: read_byte[7:0].
    output logic [mfde_pkg::OUT_DATA_W-1:0] m_tdata,
    // Register port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mfde_pkg::PADDR_W-1:0]    paddr,
    input  logic [mfde_pkg::PDATA_W-1:0]    pwdata,
    output logic [mfde_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import mfde_pkg::*;

    localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    top_state_t        state_reg, state_next;
    logic              invert_reg;
    logic [ADDR_W-1:0] swp_reg, swp_next;
    logic [7:0]        fill_reg, fill_next;
    logic [9:0]        rd_addr_reg, rd_addr_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic [7:0]        wr_mask_reg, wr_mask_next;
    logic              wr_set_reg, wr_set_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg, out_data_next;

    cmd_t              cmd_in;
    logic              accept;
    logic              out_free;
    logic              rd_beyond;
    logic              walk_start;
    logic              walk_take;
    logic              walk_busy;
    wr_req_t           acc;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic              cfg_wr;

    assign cmd_in    = cmd_t'(s_tdata[$bits(cmd_t)-1:0]);
    assign s_tready  = (state_reg == T_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign rd_beyond = (14'(rd_addr_reg) >= 14'(STORE_BYTES));
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Register port: a single register, always ready.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_INVERT_COLOUR);
    assign prdata = (paddr == ADDR_INVERT_COLOUR) ? PDATA_W'(invert_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            invert_reg <= pwdata[0];
        end
    end

    // Drawing commands are handed to the walker on the accepting edge.
    always_comb
    begin
        walk_start = 1'b0;
        if (accept)
        begin
            case (op_t'(cmd_in.op))
                OP_PIXEL:  walk_start = 1'b1;
                OP_RECT:   walk_start = 1'b1;
                OP_CIRCLE: walk_start = 1'b1;
                default:   walk_start = 1'b0;
            endcase
        end
    end

    mfde_walker #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_walker (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (walk_start),
        .cmd    (cmd_in),
        .invert (invert_reg),
        .take   (walk_take),
        .acc    (acc),
        .busy   (walk_busy)
    );

    mfde_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_SWEEP:
            begin
                if (swp_reg == ADDR_W'(STORE_BYTES - 1))
                begin
                    state_next = T_IDLE;
                end
            end
            T_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(cmd_in.op))
                        OP_FILL:   state_next = T_SWEEP;
                        OP_PIXEL:  state_next = T_DRAW;
                        OP_RECT:   state_next = T_DRAW;
                        OP_CIRCLE: state_next = T_DRAW;
                        OP_READ:   state_next = T_READ;
                        default:   state_next = T_IDLE;
                    endcase
                end
            end
            T_DRAW:
            begin
                if (acc.valid)
                begin
                    state_next = T_DRAW_WR;
                end
                else if (!walk_busy)
                begin
                    state_next = T_IDLE;
                end
            end
            T_DRAW_WR:
            begin
                state_next = T_DRAW;
            end
            T_READ:
            begin
                if (out_free)
                begin
                    state_next = rd_beyond ? T_IDLE : T_READ_WAIT;
                end
            end
            T_READ_WAIT:
            begin
                state_next = T_IDLE;
            end
            default: state_next = T_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        swp_next       = swp_reg;
        fill_next      = fill_reg;
        rd_addr_next   = rd_addr_reg;
        wr_addr_next   = wr_addr_reg;
        wr_mask_next   = wr_mask_reg;
        wr_set_next    = wr_set_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        walk_take      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = wr_addr_reg;
        ram_wdata      = 8'h00;
        ram_raddr      = acc.addr[ADDR_W-1:0];
        case (state_reg)
            T_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = swp_reg;
                ram_wdata = fill_reg;
                swp_next  = swp_reg + ADDR_W'(1);
            end
            T_IDLE:
            begin
                if (accept)
                begin
                    swp_next     = '0;
                    fill_next    = cmd_in.colour ? 8'hFF : 8'h00;
                    rd_addr_next = cmd_in.byte_address;
                end
            end
            T_DRAW:
            begin
                if (acc.valid)
                begin
                    walk_take    = 1'b1;
                    wr_addr_next = acc.addr[ADDR_W-1:0];
                    wr_mask_next = acc.mask;
                    wr_set_next  = acc.set;
                end
            end
            T_DRAW_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = wr_addr_reg;
                ram_wdata = wr_set_reg ? (ram_rdata | wr_mask_reg) : (ram_rdata & ~wr_mask_reg);
            end
            T_READ:
            begin
                ram_raddr = ADDR_W'(rd_addr_reg);
                if (out_free && rd_beyond)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = 8'h00;
                end
            end
            T_READ_WAIT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = ram_rdata;
            end
            default:
            begin
                walk_take = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_SWEEP;
            swp_reg       <= '0;
            fill_reg      <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            swp_reg       <= swp_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= rd_addr_next;
        wr_addr_reg  <= wr_addr_next;
        wr_mask_reg  <= wr_mask_next;
        wr_set_reg   <= wr_set_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    // The buffer is never written in a cycle that takes a new command.
    a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !accept)
        else $error("buffer write while a command is accepted");

    // Every write-back follows the read of the same update.
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_DRAW_WR) |-> ($past(state_reg) == T_DRAW))
        else $error("write-back without a preceding read");

    // A new read result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_READ_WAIT) |-> !out_valid_reg)
        else $error("read result would overwrite a pending result");

    // The walker only starts a command when it has finished the previous one.
    a_walker_idle: assert property (@(posedge clk) disable iff (!rst_n)
        walk_start |-> !walk_busy)
        else $error("walker started while busy");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

// Drives draw and read requests into the framebuffer engine and checks every
// read request against a local copy of the buffer that is updated with the same
// drawing rules (clipping, colour inversion, rectangle ordering, midpoint circle).
module tb_top;
    import mfde_pkg::*;

    localparam int WIDTH = 128;
    localparam int HEIGHT = 64;
    localparam int NBYTES = WIDTH * ((HEIGHT + 7) / 8);

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    mono_framebuffer_draw_engine uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The local picture of the screen and the invert setting it is drawn with.
    logic [7:0] shadow_fb [NBYTES];
    logic shadow_invert;
    logic [7:0] read_bytes_due [$];
    int error_count;
    bit idle_on;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic void plot(input int x, input int y, input logic col);
        int idx;
        logic c;
        if (x < 0 || y < 0 || x >= WIDTH || y >= HEIGHT)
            return;
        c = col ^ shadow_invert;
        idx = x + (y / 8) * WIDTH;
        shadow_fb[idx][y % 8] = c;
    endfunction

    // Applies one command to the local buffer; returns 1 when a read byte is due.
    function automatic bit apply_command(input cmd_t c, output logic [7:0] rd);
        int lx, hx, ly, hy, cx, cy, r, f, ddx, ddy, px, py;
        rd = 8'h00;
        case (c.op)
            OP_PIXEL: plot(c.x_first, c.y_first, c.colour);
            OP_FILL:
                for (int i = 0; i < NBYTES; i++)
                    shadow_fb[i] = c.colour ? 8'hFF : 8'h00;
            OP_RECT:
            begin
                lx = (c.x_first < c.x_second) ? c.x_first : c.x_second;
                hx = (c.x_first < c.x_second) ? c.x_second : c.x_first;
                ly = (c.y_first < c.y_second) ? c.y_first : c.y_second;
                hy = (c.y_first < c.y_second) ? c.y_second : c.y_first;
                for (int i = lx; i <= hx; i++)
                    for (int j = ly; j < hy; j++)
                        plot(i, j, c.colour);
            end
            OP_CIRCLE:
            begin
                cx = c.x_first;
                cy = c.y_first;
                r = c.circle_radius;
                f = 1 - r;
                ddx = 1;
                ddy = -2 * r;
                px = 0;
                py = r;
                plot(cx, cy + r, c.colour);
                plot(cx, cy - r, c.colour);
                plot(cx + r, cy, c.colour);
                plot(cx - r, cy, c.colour);
                while (px < py)
                begin
                    if (f >= 0)
                    begin
                        py--;
                        ddy += 2;
                        f += ddy;
                    end
                    px++;
                    ddx += 2;
                    f += ddx;
                    plot(cx + px, cy + py, c.colour);
                    plot(cx - px, cy + py, c.colour);
                    plot(cx + px, cy - py, c.colour);
                    plot(cx - px, cy - py, c.colour);
                    plot(cx + py, cy + px, c.colour);
                    plot(cx - py, cy + px, c.colour);
                    plot(cx + py, cy - px, c.colour);
                    plot(cx - py, cy - px, c.colour);
                end
            end
            OP_READ:
            begin
                rd = (c.byte_address < NBYTES) ? shadow_fb[c.byte_address] : 8'h00;
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic cmd_t make_cmd(input logic [2:0] op, input int xf, input int yf,
                                      input int xs, input int ys, input int rad,
                                      input logic col, input int addr);
        cmd_t c;
        c.op = op;
        c.x_first = 8'(xf);
        c.y_first = 8'(yf);
        c.x_second = 8'(xs);
        c.y_second = 8'(ys);
        c.circle_radius = 7'(rad);
        c.colour = col;
        c.byte_address = 10'(addr);
        return c;
    endfunction

    // Random command, weighted toward small shapes on screen and plenty of reads.
    function automatic cmd_t random_cmd();
        cmd_t c;
        int sel;
        c = '0;
        c.x_first = 8'($urandom);
        c.y_first = 8'($urandom);
        c.x_second = 8'($urandom);
        c.y_second = 8'($urandom);
        c.circle_radius = 7'($urandom);
        c.colour = 1'($urandom);
        c.byte_address = 10'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 30)
        begin
            c.op = OP_READ;
            if ($urandom_range(0, 9) != 0)
                c.byte_address = 10'($urandom_range(0, NBYTES - 1));
        end
        else if (sel < 55)
        begin
            c.op = OP_PIXEL;
            if ($urandom_range(0, 4) != 0)
            begin
                c.x_first = 8'($urandom_range(0, WIDTH - 1));
                c.y_first = 8'($urandom_range(0, HEIGHT - 1));
            end
        end
        else if (sel < 75)
        begin
            c.op = OP_RECT;
            if ($urandom_range(0, 7) != 0)
            begin
                c.x_first = 8'($urandom_range(0, WIDTH - 1));
                c.y_first = 8'($urandom_range(0, HEIGHT - 1));
                c.x_second = 8'(int'(c.x_first) + int'($urandom_range(0, 12)) - 6);
                c.y_second = 8'(int'(c.y_first) + int'($urandom_range(0, 12)) - 6);
            end
        end
        else if (sel < 95)
        begin
            c.op = OP_CIRCLE;
            if ($urandom_range(0, 7) != 0)
            begin
                c.x_first = 8'($urandom_range(0, WIDTH - 1));
                c.y_first = 8'($urandom_range(0, HEIGHT - 1));
                c.circle_radius = 7'($urandom_range(0, 20));
            end
        end
        else if (sel < 97)
            c.op = OP_FILL;
        else
            c.op = 3'($urandom_range(5, 7));
        return c;
    endfunction

    // Gaps between requests come in random bursts; none when idling is switched off.
    // Outside drain, the valid line only drops when a gap is taken.
    task automatic maybe_gap();
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    // Leaves the valid line high on return so that the next request can follow
    // without a gap.
    task automatic send_cmd(input cmd_t c);
        logic [7:0] rd;
        maybe_gap();
        s_tdata <= IN_DATA_W'(c);
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (apply_command(c, rd))
            read_bytes_due.push_back(rd);
        @(negedge clk);
    endtask

    task automatic write_invert(input logic value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_INVERT_COLOUR;
        pwdata <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        shadow_invert = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Waits for all read requests to come back and for the engine to finish drawing.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (read_bytes_due.size() != 0)
            @(negedge clk);
        repeat (3000) @(negedge clk);
    endtask

    // Output side: random backpressure in bursts, check against oldest expected byte.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (read_bytes_due.size() == 0)
                report_mismatch("unexpected read_byte", m_tdata, -1);
            else
            begin
                if (m_tdata !== read_bytes_due[0])
                    report_mismatch("read_byte", m_tdata, read_bytes_due[0]);
                void'(read_bytes_due.pop_front());
            end
        end
    end

    initial
    begin
        int stall;
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                m_tready <= (stall == 0);
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 18);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Directed table: fields follow cmd_t; want is -1 where the predictor decides.
    typedef struct {
        cmd_t cmd;
        int want;
    } directed_row_t;

    directed_row_t rows [$];

    initial
    begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [7:0] rd;
        error_count = 0;
        shadow_invert = 1'b0;
        idle_on = 1'b1;
        for (int i = 0; i < NBYTES; i++)
            shadow_fb[i] = 8'h00;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // After reset the screen reads as cleared, including the far corner.
        rows.push_back('{make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0), 0});
        rows.push_back('{make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, NBYTES - 1), 0});
        rows.push_back('{make_cmd(OP_PIXEL, 0, 0, 0, 0, 0, 1, 0), -1});
        rows.push_back('{make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1});
        rows.push_back('{make_cmd(OP_PIXEL, 127, 63, 0, 0, 0, 1, 0), -1});
        rows.push_back('{make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, NBYTES - 1), 8'h80});
        // Off-screen pixel is clipped, not wrapped.
        rows.push_back('{make_cmd(OP_PIXEL, 255, 255, 0, 0, 0, 1, 0), -1});
        rows.push_back('{make_cmd(OP_PIXEL, 128, 0, 0, 0, 0, 1, 0), -1});
        rows.push_back('{make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 1), 0});
        // The highest address still holds the bottom right pixel.
        rows.push_back('{make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 1023), 8'h80});
        rows.push_back('{make_cmd(OP_FILL, 0, 0, 0, 0, 0, 1, 0), -1});
        rows.push_back('{make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 500), 8'hFF});
        rows.push_back('{make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 1023), 8'hFF});
        // Reversed rectangle corners, equal y draws nothing, wide clipped rectangle.
        rows.push_back('{make_cmd(OP_RECT, 20, 10, 5, 2, 0, 0, 0), -1});
        rows.push_back('{make_cmd(OP_RECT, 40, 5, 60, 5, 0, 0, 0), -1});
        rows.push_back('{make_cmd(OP_RECT, 255, 255, 100, 50, 0, 0, 0), -1});
        rows.push_back('{make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 5), -1});
        rows.push_back('{make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 40), 8'hFF});
        // Zero radius, clipped circle, the largest radius.
        rows.push_back('{make_cmd(OP_CIRCLE, 64, 32, 0, 0, 0, 0, 0), -1});
        rows.push_back('{make_cmd(OP_CIRCLE, 0, 0, 0, 0, 10, 0, 0), -1});
        rows.push_back('{make_cmd(OP_CIRCLE, 255, 255, 0, 0, 127, 0, 0), -1});
        rows.push_back('{make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 64 + 4 * WIDTH), -1});
        // Unused op codes are ignored.
        rows.push_back('{make_cmd(3'd5, 0, 0, 0, 0, 0, 0, 0), -1});
        rows.push_back('{make_cmd(3'd7, 255, 255, 255, 255, 127, 1, 1023), -1});
        rows.push_back('{make_cmd(OP_FILL, 0, 0, 0, 0, 0, 0, 0), -1});

        foreach (rows[i])
        begin
            if (rows[i].want >= 0 && rows[i].cmd.op == OP_READ)
            begin
                void'(apply_command(rows[i].cmd, rd));
                if (rd !== rows[i].want[7:0])
                    report_mismatch("directed table", rd, rows[i].want);
            end
            send_cmd(rows[i].cmd);
        end
        drain();

        // Random phases under each invert setting, ending with no idling.
        for (int phase = 0; phase < 4; phase++)
        begin
            write_invert(phase[0]);
            if (phase == 3)
                idle_on = 1'b0;
            for (int n = 0; n < 475; n++)
                send_cmd(random_cmd());
            drain();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
